### design/lhh_pkg.sv
// ----------------------------------------------------------------------------
// lhh_pkg: shared types and constants for the link hello handshake
// Command, packet kind and route codes, plus the beat, state and result
// structures passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package lhh_pkg;

    // Width of the millisecond time base.
    localparam int TIME_BITS = 32;

    // Command codes.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_RECV   = 3'd1;
    localparam logic [2:0] CMD_SEND   = 3'd2;
    localparam logic [2:0] CMD_SERIAL = 3'd3;
    localparam logic [2:0] CMD_TELEM  = 3'd4;

    // Packet and frame kinds.
    localparam logic [2:0] KIND_HELLO  = 3'd0;
    localparam logic [2:0] KIND_ACK    = 3'd1;
    localparam logic [2:0] KIND_SERIAL = 3'd2;
    localparam logic [2:0] KIND_TELEM  = 3'd3;
    localparam logic [2:0] KIND_OTHER  = 3'd4;

    // Routes.
    localparam logic [1:0] ROUTE_NONE   = 2'd0;
    localparam logic [1:0] ROUTE_FRAMED = 2'd1;
    localparam logic [1:0] ROUTE_RAW    = 2'd2;
    localparam logic [1:0] ROUTE_PLAIN  = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic CFG_HELLO_INTERVAL = 1'b0;
    localparam logic CFG_READY_TIMEOUT  = 1'b1;
    localparam logic [15:0] HELLO_INTERVAL_RESET = 16'd500;
    localparam logic [15:0] READY_TIMEOUT_RESET  = 16'd3000;

    // One input beat.
    typedef struct packed {
        logic [2:0]           command;
        logic [TIME_BITS-1:0] now_ms;
        logic                 phy_active;
        logic                 wireless_selected;
        logic [2:0]           packet_kind;
    } item_t;

    // Configuration seen by the step logic.
    typedef struct packed {
        logic [15:0] hello_interval_ms;
        logic [15:0] ready_timeout_ms;
    } cfg_t;

    // Handshake state; a zero time means unset.
    typedef struct packed {
        logic                 ready_flag;
        logic                 hello_seen_flag;
        logic [TIME_BITS-1:0] last_hello_time;
        logic [TIME_BITS-1:0] wait_start_time;
    } link_state_t;

    // One result beat.
    typedef struct packed {
        logic       send_frame;
        logic [2:0] frame_kind;
        logic [1:0] route;
        logic       request_search;
        logic       handled;
        logic       rejected;
        logic       link_up;
    } result_t;

endpackage

### design/lhh_step.sv
// ----------------------------------------------------------------------------
// lhh_step: next-state and result logic for one beat
// Purely combinational: takes the registered beat, the current handshake
// state and the configuration, and gives the next state and the result.
// ----------------------------------------------------------------------------
module lhh_step
    import lhh_pkg::*;
(
    input  item_t       item,
    input  cfg_t        cfg,
    input  link_state_t state,
    output link_state_t state_next,
    output result_t     result
);

    // Framed transmission of one kind, with the raw fallback for control frames.
    function automatic result_t framed_send(input logic [2:0] kind, input logic phy,
                                            input logic wireless);
        result_t r;
        r = '0;
        if (!phy)
        begin
            r.rejected = 1'b1;
        end
        else if (wireless)
        begin
            r.send_frame = 1'b1;
            r.frame_kind = kind;
            r.route      = ROUTE_FRAMED;
        end
        else if (kind != KIND_HELLO && kind != KIND_ACK)
        begin
            r.rejected = 1'b1;
        end
        else
        begin
            r.send_frame = 1'b1;
            r.frame_kind = kind;
            r.route      = ROUTE_RAW;
        end
        return r;
    endfunction

    logic [2:0]           kind;
    logic [TIME_BITS-1:0] wait_elapsed;
    logic [TIME_BITS-1:0] hello_elapsed;
    logic                 timed_out;
    logic                 hello_due;

    // Out-of-range packet kinds count as other.
    assign kind = (item.packet_kind > KIND_OTHER) ? KIND_OTHER : item.packet_kind;

    // Wrapping time differences against both timers.
    assign wait_elapsed  = item.now_ms - state.wait_start_time;
    assign hello_elapsed = item.now_ms - state.last_hello_time;
    assign timed_out = (wait_elapsed >= {{(TIME_BITS-16){1'b0}}, cfg.ready_timeout_ms});
    assign hello_due = (state.last_hello_time == '0) ||
                       (hello_elapsed >= {{(TIME_BITS-16){1'b0}}, cfg.hello_interval_ms});

    // Command decode.
    always_comb
    begin
        state_next = state;
        result     = '0;
        case (item.command)
            CMD_TICK:
            begin
                if (!item.phy_active)
                begin
                    state_next = '0;
                end
                else if (state.ready_flag)
                begin
                    state_next.wait_start_time = '0;
                end
                else if (state.wait_start_time != '0 && timed_out)
                begin
                    result.request_search      = 1'b1;
                    state_next.hello_seen_flag = 1'b0;
                    state_next.last_hello_time = '0;
                    state_next.wait_start_time = item.now_ms;
                end
                else
                begin
                    if (state.wait_start_time == '0)
                    begin
                        state_next.wait_start_time = item.now_ms;
                    end
                    if (hello_due)
                    begin
                        state_next.last_hello_time = item.now_ms;
                        result = framed_send(KIND_HELLO, item.phy_active,
                                             item.wireless_selected);
                    end
                end
            end
            CMD_RECV:
            begin
                if (kind == KIND_HELLO)
                begin
                    state_next.hello_seen_flag = 1'b1;
                    result = framed_send(KIND_ACK, item.phy_active, item.wireless_selected);
                    result.handled = 1'b1;
                end
                else if (kind == KIND_ACK)
                begin
                    state_next.hello_seen_flag = 1'b1;
                    state_next.ready_flag      = 1'b1;
                    state_next.wait_start_time = '0;
                    result.handled             = 1'b1;
                end
            end
            CMD_SEND:
            begin
                result = framed_send(kind, item.phy_active, item.wireless_selected);
            end
            CMD_SERIAL, CMD_TELEM:
            begin
                if (item.wireless_selected && item.phy_active)
                begin
                    if (!state.ready_flag)
                    begin
                        result.rejected = 1'b1;
                    end
                    else
                    begin
                        result = framed_send((item.command == CMD_SERIAL) ? KIND_SERIAL
                                                                          : KIND_TELEM,
                                             item.phy_active, item.wireless_selected);
                    end
                end
                else
                begin
                    result.send_frame = 1'b1;
                    result.frame_kind = (item.command == CMD_SERIAL) ? KIND_SERIAL
                                                                     : KIND_TELEM;
                    result.route      = ROUTE_PLAIN;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
        result.link_up = item.phy_active && state_next.ready_flag;
    end

endmodule

### design/link_hello_handshake_top.sv
// ----------------------------------------------------------------------------
// link_hello_handshake_top: link bring-up hello/ack handshake
// Input register, single-pass step logic and a result register.
// ----------------------------------------------------------------------------
// Path: an accepted input beat waits in the input register and moves into the
// result register when that register advances; out_valid then shows it.
// Throughput: one beat per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset: all handshake state and valid flags clear; the hello interval resets
// to 500 ms and the ready timeout to 3000 ms.
module link_hello_handshake_top
    import lhh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           command,
    input  logic [TIME_BITS-1:0] now_ms,
    input  logic                 phy_active,
    input  logic                 wireless_selected,
    input  logic [2:0]           packet_kind,
    // Result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 send_frame,
    output logic [2:0]           frame_kind,
    output logic [1:0]           route,
    output logic                 request_search,
    output logic                 handled,
    output logic                 rejected,
    output logic                 link_up
);

    cfg_t        cfg_reg;
    link_state_t state_reg;
    link_state_t state_next;
    item_t       item_reg;
    logic        item_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        out_valid_reg;
    logic        advance;
    logic        in_take;

    // Pipeline flow control.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_take  = !item_valid_reg || advance;
    assign in_stall = !in_take;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hello_interval_ms <= HELLO_INTERVAL_RESET;
            cfg_reg.ready_timeout_ms  <= READY_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_HELLO_INTERVAL: cfg_reg.hello_interval_ms <= cfg_data;
                CFG_READY_TIMEOUT:  cfg_reg.ready_timeout_ms  <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && in_valid)
        begin
            item_reg.command           <= command;
            item_reg.now_ms            <= now_ms;
            item_reg.phy_active        <= phy_active;
            item_reg.wireless_selected <= wireless_selected;
            item_reg.packet_kind       <= packet_kind;
        end
    end

    // Step logic.
    lhh_step u_step (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Handshake state commits when the beat moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (item_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // Output ports.
    assign out_valid      = out_valid_reg;
    assign send_frame     = result_reg.send_frame;
    assign frame_kind     = result_reg.frame_kind;
    assign route          = result_reg.route;
    assign request_search = result_reg.request_search;
    assign handled        = result_reg.handled;
    assign rejected       = result_reg.rejected;
    assign link_up        = result_reg.link_up;

    // A beat with nothing sent carries no kind and no route.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.send_frame) |->
        (result_reg.frame_kind == KIND_HELLO && result_reg.route == ROUTE_NONE))
        else $error("idle result carries a frame kind or route");

    // A rejected request or a search request never transmits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.send_frame &&
                            (result_reg.rejected || result_reg.request_search)))
        else $error("transmission together with reject or search");

    // A beat leaving the input register shows up at the output next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && advance) |=> out_valid_reg)
        else $error("result beat lost");

    // Once the physical link drops on a tick, the handshake state is cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && advance && item_reg.command == CMD_TICK &&
         !item_reg.phy_active) |=> (state_reg == '0))
        else $error("state not cleared on link down");

endmodule

### test/link_hello_handshake_top_tb.sv
// ----------------------------------------------------------------------------
// link_hello_handshake_top_tb: self-checking bench for the link hello handshake
// Drives command beats through the valid/stall input channel, predicts every
// result beat with a behavioral model of the handshake state, and compares the
// result channel field by field. The run covers directed corner cases, extreme
// register settings and random traffic under several idle and stall patterns.
// ----------------------------------------------------------------------------
module link_hello_handshake_top_tb;
    import lhh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Clock, reset and block inputs, all known from time zero.
    logic                 clk               = 1'b0;
    logic                 rst_n             = 1'b0;
    logic                 cfg_write         = 1'b0;
    logic                 cfg_index         = CFG_HELLO_INTERVAL;
    logic [15:0]          cfg_data          = '0;
    logic                 in_valid          = 1'b0;
    logic [2:0]           command           = CMD_TICK;
    logic [TIME_BITS-1:0] now_ms            = '0;
    logic                 phy_active        = 1'b0;
    logic                 wireless_selected = 1'b0;
    logic [2:0]           packet_kind       = KIND_HELLO;
    logic                 out_stall         = 1'b0;

    // Block outputs.
    logic       in_stall;
    logic       out_valid;
    logic       send_frame;
    logic [2:0] frame_kind;
    logic [1:0] route;
    logic       request_search;
    logic       handled;
    logic       rejected;
    logic       link_up;

    // Shadow copy of the handshake state and registers.
    logic [15:0]          m_interval   = HELLO_INTERVAL_RESET;
    logic [15:0]          m_timeout    = READY_TIMEOUT_RESET;
    logic                 m_ready      = 1'b0;
    logic                 m_hello_seen = 1'b0;
    logic [TIME_BITS-1:0] m_last_hello = '0;
    logic [TIME_BITS-1:0] m_wait_start = '0;

    // Expected result beats, oldest first.
    result_t pending_results[$];

    // Traffic controls and bookkeeping.
    int unsigned          idle_pct        = 0;
    int unsigned          stall_pct       = 0;
    logic [TIME_BITS-1:0] sim_now         = '0;
    int unsigned          beats_sent      = 0;
    int unsigned          results_checked = 0;
    int unsigned          config_sets     = 1;
    int unsigned          error_count     = 0;
    int unsigned          quiet_cycles    = 0;

    link_hello_handshake_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .now_ms            (now_ms),
        .phy_active        (phy_active),
        .wireless_selected (wireless_selected),
        .packet_kind       (packet_kind),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .send_frame        (send_frame),
        .frame_kind        (frame_kind),
        .route             (route),
        .request_search    (request_search),
        .handled           (handled),
        .rejected          (rejected),
        .link_up           (link_up)
    );

    // Free-running clock with a period of 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Framed transmission of one kind: over the transport on wireless, raw to
    // the link device for hello and ack otherwise, refused with phy down.
    function automatic result_t frame_route(logic [2:0] kind, logic phy, logic wireless,
                                            result_t r);
        if (!phy)
            r.rejected = 1'b1;
        else if (wireless)
        begin
            r.send_frame = 1'b1;
            r.frame_kind = kind;
            r.route      = ROUTE_FRAMED;
        end
        else if (kind != KIND_HELLO && kind != KIND_ACK)
            r.rejected = 1'b1;
        else
        begin
            r.send_frame = 1'b1;
            r.frame_kind = kind;
            r.route      = ROUTE_RAW;
        end
        return r;
    endfunction

    // Advances the shadow state by one beat and returns the result it causes.
    function automatic result_t predict_link_step(item_t it);
        result_t              r;
        logic [2:0]           kind;
        logic [2:0]           data_kind;
        logic [TIME_BITS-1:0] elapsed;
        logic                 hello_due;
        r    = '0;
        kind = (it.packet_kind > KIND_OTHER) ? KIND_OTHER : it.packet_kind;
        case (it.command)
            CMD_TICK:
            begin
                if (!it.phy_active)
                begin
                    m_ready      = 1'b0;
                    m_hello_seen = 1'b0;
                    m_last_hello = '0;
                    m_wait_start = '0;
                end
                else if (m_ready)
                    m_wait_start = '0;
                else
                begin
                    hello_due = 1'b1;
                    elapsed   = it.now_ms - m_wait_start;
                    if (m_wait_start == '0)
                        m_wait_start = it.now_ms;
                    else if (elapsed >= {16'd0, m_timeout})
                    begin
                        r.request_search = 1'b1;
                        m_hello_seen     = 1'b0;
                        m_last_hello     = '0;
                        m_wait_start     = it.now_ms;
                        hello_due        = 1'b0;
                    end
                    elapsed = it.now_ms - m_last_hello;
                    if (hello_due && m_last_hello != '0 && elapsed < {16'd0, m_interval})
                        hello_due = 1'b0;
                    if (hello_due)
                    begin
                        m_last_hello = it.now_ms;
                        r = frame_route(KIND_HELLO, it.phy_active, it.wireless_selected, r);
                    end
                end
            end
            CMD_RECV:
            begin
                if (kind == KIND_HELLO)
                begin
                    m_hello_seen = 1'b1;
                    r.handled    = 1'b1;
                    r = frame_route(KIND_ACK, it.phy_active, it.wireless_selected, r);
                end
                else if (kind == KIND_ACK)
                begin
                    m_hello_seen = 1'b1;
                    m_ready      = 1'b1;
                    m_wait_start = '0;
                    r.handled    = 1'b1;
                end
            end
            CMD_SEND:
                r = frame_route(kind, it.phy_active, it.wireless_selected, r);
            CMD_SERIAL, CMD_TELEM:
            begin
                data_kind = (it.command == CMD_SERIAL) ? KIND_SERIAL : KIND_TELEM;
                if (it.wireless_selected && it.phy_active)
                begin
                    if (!m_ready)
                        r.rejected = 1'b1;
                    else
                        r = frame_route(data_kind, 1'b1, 1'b1, r);
                end
                else
                begin
                    r.send_frame = 1'b1;
                    r.frame_kind = data_kind;
                    r.route      = ROUTE_PLAIN;
                end
            end
            default:
                ;
        endcase
        r.link_up = it.phy_active && m_ready;
        return r;
    endfunction

    // Builds one command beat.
    function automatic item_t link_beat(logic [2:0] cmd, logic [TIME_BITS-1:0] now,
                                        logic phy, logic wireless, logic [2:0] kind);
        item_t it;
        it.command           = cmd;
        it.now_ms            = now;
        it.phy_active        = phy;
        it.wireless_selected = wireless;
        it.packet_kind       = kind;
        return it;
    endfunction

    // Random beat: mostly ticks with a time that moves on plausibly, hellos,
    // acks and sends, plus some fully random noise.
    function automatic item_t random_link_beat();
        item_t       it;
        int unsigned pick;
        int unsigned span;
        it.now_ms            = $urandom();
        it.phy_active        = ($urandom_range(99) < 90);
        it.wireless_selected = 1'($urandom_range(1));
        it.packet_kind       = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            it.command = CMD_TICK;
            span = ($urandom_range(1) ? m_interval : m_timeout) + 2;
            case ($urandom_range(19))
                0:       sim_now = $urandom();
                1:       sim_now = '0;
                2:       sim_now = 32'hFFFF_FFFF - $urandom_range(span);
                default: sim_now = sim_now + $urandom_range(span);
            endcase
            it.now_ms = sim_now;
        end
        else if (pick < 72)
        begin
            it.command = CMD_RECV;
            case ($urandom_range(5))
                0, 1, 2: it.packet_kind = KIND_HELLO;
                3:       it.packet_kind = KIND_ACK;
                default: ;
            endcase
        end
        else if (pick < 94)
            it.command = 3'($urandom_range(CMD_SEND, CMD_TELEM));
        else
            it.command = 3'($urandom_range(7));
        return it;
    endfunction

    // Sends one beat, holds it through stalls, then idles at random.
    task automatic send_beat(input item_t it);
        command           <= it.command;
        now_ms            <= it.now_ms;
        phy_active        <= it.phy_active;
        wireless_selected <= it.wireless_selected;
        packet_kind       <= it.packet_kind;
        in_valid          <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_link_step(it));
        beats_sent++;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Stops sending and waits until every expected result beat has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes both registers back to back while the block is idle.
    task automatic write_config(input logic [15:0] interval, input logic [15:0] timeout);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= CFG_HELLO_INTERVAL;
        cfg_data  <= interval;
        @(negedge clk);
        cfg_index <= CFG_READY_TIMEOUT;
        cfg_data  <= timeout;
        @(negedge clk);
        cfg_write <= 1'b0;
        m_interval = interval;
        m_timeout  = timeout;
        config_sets++;
        @(negedge clk);
    endtask

    // Corner cases under the reset register values.
    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        // Time zero leaves the wait timer unset; hello goes out framed.
        send_beat(link_beat(CMD_TICK, 32'd0, 1'b1, 1'b1, KIND_HELLO));
        send_beat(link_beat(CMD_TICK, 32'd100, 1'b1, 1'b1, KIND_HELLO));
        // Inside the hello interval nothing is sent; after it, hello goes raw.
        send_beat(link_beat(CMD_TICK, 32'd300, 1'b1, 1'b0, KIND_HELLO));
        send_beat(link_beat(CMD_TICK, 32'd700, 1'b1, 1'b0, KIND_HELLO));
        // Ready timeout expires exactly and a new search is requested.
        send_beat(link_beat(CMD_TICK, 32'd3100, 1'b1, 1'b1, KIND_HELLO));
        // Received hello with phy down, then answered framed and raw.
        send_beat(link_beat(CMD_RECV, 32'hFFFF_FFFF, 1'b0, 1'b1, KIND_HELLO));
        send_beat(link_beat(CMD_RECV, 32'd0, 1'b1, 1'b1, KIND_HELLO));
        send_beat(link_beat(CMD_RECV, 32'd0, 1'b1, 1'b0, KIND_HELLO));
        // Data sends before the link is ready.
        send_beat(link_beat(CMD_SERIAL, 32'd0, 1'b1, 1'b1, KIND_OTHER));
        send_beat(link_beat(CMD_TELEM, 32'd0, 1'b0, 1'b1, KIND_OTHER));
        send_beat(link_beat(CMD_SERIAL, 32'd0, 1'b1, 1'b0, KIND_OTHER));
        // Ack makes the link ready; a tick then only clears the wait timer.
        send_beat(link_beat(CMD_RECV, 32'd0, 1'b1, 1'b1, KIND_ACK));
        send_beat(link_beat(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_HELLO));
        send_beat(link_beat(CMD_SERIAL, 32'd0, 1'b1, 1'b1, KIND_HELLO));
        send_beat(link_beat(CMD_TELEM, 32'd0, 1'b1, 1'b1, KIND_HELLO));
        // Plain sends: unknown kind, refused kind, raw ack, phy down.
        send_beat(link_beat(CMD_SEND, 32'd0, 1'b1, 1'b1, 3'd7));
        send_beat(link_beat(CMD_SEND, 32'd0, 1'b1, 1'b0, KIND_SERIAL));
        send_beat(link_beat(CMD_SEND, 32'd0, 1'b1, 1'b0, KIND_ACK));
        send_beat(link_beat(CMD_SEND, 32'd0, 1'b0, 1'b1, KIND_HELLO));
        // Received non-control packets and unknown commands do nothing.
        send_beat(link_beat(CMD_RECV, 32'd0, 1'b1, 1'b1, KIND_TELEM));
        send_beat(link_beat(CMD_RECV, 32'd0, 1'b1, 1'b1, 3'd5));
        send_beat(link_beat(3'd5, 32'd0, 1'b1, 1'b1, KIND_HELLO));
        send_beat(link_beat(3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7));
        // Phy down clears everything; then time differences across the wrap.
        send_beat(link_beat(CMD_TICK, 32'd0, 1'b0, 1'b1, KIND_HELLO));
        send_beat(link_beat(CMD_TICK, 32'hFFFF_FF00, 1'b1, 1'b1, KIND_HELLO));
        send_beat(link_beat(CMD_TICK, 32'h0000_0100, 1'b1, 1'b1, KIND_HELLO));
        send_beat(link_beat(CMD_TICK, 32'h0000_0C00, 1'b1, 1'b1, KIND_HELLO));
    endtask

    // Extreme register settings, zero included, each with a short burst.
    task automatic test_register_extremes();
        logic [15:0] intervals [5];
        logic [15:0] timeouts  [5];
        intervals = '{16'd1, 16'd65535, 16'd0, 16'd1, 16'd65535};
        timeouts  = '{16'd1, 16'd65535, 16'd0, 16'd65535, 16'd1};
        idle_pct  = 19;
        stall_pct = 19;
        for (int s = 0; s < 5; s++)
        begin
            write_config(intervals[s], timeouts[s]);
            sim_now = $urandom();
            for (int n = 0; n < 20; n++)
                send_beat(random_link_beat());
        end
    endtask

    // Random traffic under one idle/stall pattern, with two register settings.
    task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                       input int unsigned count);
        logic [15:0] setting [2];
        idle_pct  = idle;
        stall_pct = stall;
        for (int half = 0; half < 2; half++)
        begin
            for (int r = 0; r < 2; r++)
            begin
                case ($urandom_range(3))
                    0:       setting[r] = 16'd1;
                    1:       setting[r] = 16'd65535;
                    2:       setting[r] = 16'($urandom_range(1, 65535));
                    default: setting[r] = 16'($urandom_range(1, 2000));
                endcase
            end
            write_config(setting[0], setting[1]);
            for (int n = 0; n < count / 2; n++)
                send_beat(random_link_beat());
        end
    endtask

    // Receiver stall pattern, changed at the falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Compares each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("ERROR: result beat with nothing expected at %0t", $realtime);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (send_frame !== exp_r.send_frame || frame_kind !== exp_r.frame_kind ||
                    route !== exp_r.route || request_search !== exp_r.request_search ||
                    handled !== exp_r.handled || rejected !== exp_r.rejected ||
                    link_up !== exp_r.link_up)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"ERROR: beat %0d expected send=%0d kind=%0d route=%0d ",
                                  "search=%0d handled=%0d rejected=%0d up=%0d, got ",
                                  "send=%0d kind=%0d route=%0d search=%0d handled=%0d ",
                                  "rejected=%0d up=%0d"},
                                 results_checked, exp_r.send_frame, exp_r.frame_kind,
                                 exp_r.route, exp_r.request_search, exp_r.handled,
                                 exp_r.rejected, exp_r.link_up, send_frame, frame_kind,
                                 route, request_search, handled, rejected, link_up);
                end
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding",
                         pending_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_register_extremes();
        test_random_traffic(0, 0, 200);
        test_random_traffic(80, 0, 200);
        test_random_traffic(0, 80, 200);
        test_random_traffic(19, 19, 200);
        drain_results();
        repeat (8) @(negedge clk);
        $display("Sent %0d command beats and checked %0d result beats over %0d settings,",
                 beats_sent, results_checked, config_sets);
        $display("with directed corner cases and four idle/stall patterns; %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
